/* hdl/iase_pkg.sv */
// Shared types, constants and helper functions for the infix stream evaluator.
package iase_pkg;

  // Fixed-point format and number assembly limits
  localparam int FRAC_BITS = 32;
  localparam int VAL_W = 64;
  localparam int INT_W = 32;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int FD_W = 30;      // holds up to MAX_FRAC_DIGITS decimal digits
  localparam int P_W = 30;       // holds 10^MAX_FRAC_DIGITS
  localparam int FC_W = 4;       // fraction digit count
  localparam int CONV_CNT_W = 6;
  localparam int MUL_STEPS = VAL_W;
  localparam int DIV_STEPS = VAL_W + FRAC_BITS;
  localparam int MD_CNT_W = 7;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  // Pending multiplicative operator codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_MUL  = 2'd1;
  localparam logic [1:0] PEND_DIV  = 2'd2;

  // Character classes
  localparam logic [1:0] CLS_OTHER  = 2'd0;
  localparam logic [1:0] CLS_NUMBER = 2'd1;
  localparam logic [1:0] CLS_MULDIV = 2'd2;
  localparam logic [1:0] CLS_ADDSUB = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               divide_by_zero;
    logic               overflowed;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic number;
    logic conv_start;
    logic fold_set;
    logic md_start;
    logic md_commit;
    logic set_pending;
    logic close;
    logic set_sign;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cls;
    logic       last;
    logic [1:0] pending;
    logic       conv_done;
    logic       md_done;
    logic       out_free;
  } dp_status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    ovf;
    logic                    dz;
  } md_res_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    ovf;
  } sat_val_t;

  // Signed value from sign and magnitude, saturating
  function automatic sat_val_t make_val(input logic neg, input logic [VAL_W-1:0] m);
    sat_val_t r;
    if (neg) begin
      r.ovf = m[VAL_W-1] && (m[VAL_W-2:0] != '0);
      r.value = m[VAL_W-1] ? VAL_MIN : $signed(VAL_W'(0) - m);
    end else begin
      r.ovf = m[VAL_W-1];
      r.value = m[VAL_W-1] ? VAL_MAX : $signed(m);
    end
    return r;
  endfunction

  // Power of ten for a fraction digit count
  function automatic logic [P_W-1:0] pow10(input logic [FC_W-1:0] n);
    logic [P_W-1:0] p;
    case (n)
      4'd0: p = P_W'(1);
      4'd1: p = P_W'(10);
      4'd2: p = P_W'(100);
      4'd3: p = P_W'(1000);
      4'd4: p = P_W'(10000);
      4'd5: p = P_W'(100000);
      4'd6: p = P_W'(1000000);
      4'd7: p = P_W'(10000000);
      4'd8: p = P_W'(100000000);
      4'd9: p = P_W'(1000000000);
      default: p = P_W'(1000000000);
    endcase
    return p;
  endfunction

endpackage

/* hdl/infix_arith_stream_evaluator.sv */
// Top level of the infix arithmetic stream evaluator: controller plus datapath.
//
//   channel | direction | payload    | handshake
//   char    | in        | in_item_t  | char_valid / char_ready
//   result  | out       | out_item_t | result_valid / result_ready
//
// A digit, point or ignored character passes through decode and the after state
// only. An operator or the end mark runs a 32-step fraction conversion, then the
// shared multiply (64 steps) or divide (96 steps) unit when a term is pending.
// Worst case is a divide after a pending divide on a character that also
// carries the end mark.
// rst is synchronous and clears all control and evaluation state. A held
// result blocks only the next end mark; other characters keep flowing.
module infix_arith_stream_evaluator (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  iase_pkg::in_item_t  char_item,
  output logic                result_valid,
  input  logic                result_ready,
  output iase_pkg::out_item_t result_item
);
  import iase_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  iase_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .status     (status),
    .cmd        (cmd)
  );

  iase_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .char_item    (char_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

/* hdl/iase_ctrl.sv */
// Controller state machine sequencing character handling, folding and result output.
module iase_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  iase_pkg::dp_status_t status,
  output iase_pkg::dp_cmd_t    cmd
);
  import iase_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CONV   = 3'd2;
  localparam logic [2:0] S_MD     = 3'd3;
  localparam logic [2:0] S_CLOSE  = 3'd4;
  localparam logic [2:0] S_AFTER  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state, state_next;
  logic       end_phase, end_phase_next;
  logic       pend_md;
  logic       to_close;

  assign char_ready = (state == S_IDLE);
  assign pend_md = (status.pending == PEND_MUL) || (status.pending == PEND_DIV);
  assign to_close = end_phase || (status.cls == CLS_ADDSUB);

  // Next state and commands
  always_comb begin
    state_next = state;
    end_phase_next = end_phase;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (char_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.cls)
          CLS_NUMBER: begin
            cmd.number = 1'b1;
            state_next = S_AFTER;
          end
          CLS_MULDIV, CLS_ADDSUB: begin
            cmd.conv_start = 1'b1;
            state_next = S_CONV;
          end
          default: state_next = S_AFTER;
        endcase
      end
      S_CONV: begin
        if (status.conv_done) begin
          if (pend_md) begin
            cmd.md_start = 1'b1;
            state_next = S_MD;
          end else begin
            cmd.fold_set = 1'b1;
            if (to_close) state_next = S_CLOSE;
            else begin
              cmd.set_pending = 1'b1;
              state_next = S_AFTER;
            end
          end
        end
      end
      S_MD: begin
        if (status.md_done) begin
          cmd.md_commit = 1'b1;
          if (to_close) state_next = S_CLOSE;
          else begin
            cmd.set_pending = 1'b1;
            state_next = S_AFTER;
          end
        end
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        cmd.set_sign = !end_phase && (status.cls == CLS_ADDSUB);
        state_next = S_AFTER;
      end
      S_AFTER: begin
        if (end_phase) state_next = S_EMIT;
        else if (status.last) begin
          end_phase_next = 1'b1;
          cmd.conv_start = 1'b1;
          state_next = S_CONV;
        end else state_next = S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          end_phase_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      end_phase <= 1'b0;
    end else begin
      state <= state_next;
      end_phase <= end_phase_next;
    end
  end

endmodule

/* hdl/iase_muldiv.sv */
// Iterative fixed-point multiplier (shift-add) and divider (restoring), one bit per cycle.
module iase_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           is_div_in,
  input  logic signed [iase_pkg::VAL_W-1:0] a,
  input  logic signed [iase_pkg::VAL_W-1:0] b,
  output logic                           done,
  output iase_pkg::md_res_t              res
);
  import iase_pkg::*;

  logic                busy, is_div, neg, dz_case, a_zero, a_neg, big;
  logic [VAL_W-1:0]    ph, pl, x, q;
  logic [MD_CNT_W-1:0] cnt;
  logic [VAL_W-1:0]    ax, bx;
  logic [VAL_W:0]      msum;
  logic [VAL_W-1:0]    rs;
  logic                ge;
  logic                last_step;
  logic [2*VAL_W-1:0]  prod;
  logic [VAL_W-1:0]    mag;
  sat_val_t            mv;

  assign ax = a[VAL_W-1] ? VAL_W'(0) - a : a;
  assign bx = b[VAL_W-1] ? VAL_W'(0) - b : b;

  // One step of each operation
  assign msum = {1'b0, ph} + (pl[0] ? {1'b0, x} : '0);
  assign rs = {ph[VAL_W-2:0], pl[VAL_W-1]};
  assign ge = ph[VAL_W-1] || (rs >= x);
  assign last_step = is_div ? (cnt == MD_CNT_W'(DIV_STEPS - 1))
                            : (cnt == MD_CNT_W'(MUL_STEPS - 1));

  // Result shaping
  assign prod = {ph, pl};
  always_comb begin
    if (is_div) mag = big ? '1 : q;
    else if (prod[2*VAL_W-1:VAL_W+FRAC_BITS] != '0) mag = '1;
    else mag = prod[VAL_W+FRAC_BITS-1:FRAC_BITS];
    mv = make_val(neg, mag);
    if (dz_case) begin
      res.value = a_zero ? '0 : (a_neg ? VAL_MIN : VAL_MAX);
      res.ovf = 1'b0;
      res.dz = 1'b1;
    end else begin
      res.value = mv.value;
      res.ovf = mv.ovf;
      res.dz = 1'b0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      dz_case <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dz_case <= is_div_in && (bx == '0);
        if (is_div_in && (bx == '0)) done <= 1'b1;
        else busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      is_div <= is_div_in;
      neg <= a[VAL_W-1] ^ b[VAL_W-1];
      a_zero <= (a == '0);
      a_neg <= a[VAL_W-1];
      ph <= '0;
      pl <= is_div_in ? ax : bx;
      x <= is_div_in ? bx : ax;
      q <= '0;
      big <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + MD_CNT_W'(1);
      if (is_div) begin
        big <= big | q[VAL_W-1];
        q <= {q[VAL_W-2:0], ge};
        ph <= ge ? rs - x : rs;
        pl <= {pl[VAL_W-2:0], 1'b0};
      end else begin
        ph <= msum[VAL_W:1];
        pl <= {msum[0], pl[VAL_W-1:1]};
      end
    end
  end

endmodule

/* hdl/iase_dp.sv */
// Datapath: number assembly, decimal conversion, term and sum registers, result register.
module iase_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  iase_pkg::dp_cmd_t    cmd,
  output iase_pkg::dp_status_t status,
  input  iase_pkg::in_item_t   char_item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output iase_pkg::out_item_t  result_item
);
  import iase_pkg::*;

  logic [7:0]              ch;
  logic                    last;
  logic signed [VAL_W-1:0] running_sum, product_term;
  logic [INT_W-1:0]        int_digits;
  logic [FD_W-1:0]         frac_digits;
  logic [FC_W-1:0]         frac_count;
  logic                    nf_point, nf_second, nf_intsat;
  logic                    err_div, err_ovf;
  logic                    sign;
  logic [1:0]              pending;

  logic [P_W-1:0]          conv_r, conv_p;
  logic [FRAC_BITS-1:0]    conv_f;
  logic [CONV_CNT_W-1:0]   conv_cnt;
  logic                    conv_busy, conv_done;

  logic                    is_digit;
  logic [3:0]              dig;
  logic [INT_W+3:0]        int_new;
  logic [FD_W+3:0]         frac_new;
  logic [P_W:0]            r2;
  logic                    r_ge;
  logic                    rnd;
  logic [FRAC_BITS:0]      f_round;
  logic                    conv_sat;
  logic signed [VAL_W-1:0] num_val;
  logic [P_W-1:0]          start_p;

  logic signed [VAL_W-1:0] addend, sum_raw, sum_sat;
  logic                    add_ovf;

  logic                    md_done;
  md_res_t                 md_res;

  // Character classification
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig = ch[3:0];
  assign status.cls = (is_digit || ch == CH_POINT) ? CLS_NUMBER
                    : (ch == CH_STAR || ch == CH_SLASH) ? CLS_MULDIV
                    : (ch == CH_PLUS || ch == CH_MINUS) ? CLS_ADDSUB
                    : CLS_OTHER;
  assign status.last = last;
  assign status.pending = pending;
  assign status.conv_done = conv_done;
  assign status.md_done = md_done;
  assign status.out_free = !result_valid || result_ready;

  // Decimal digit accumulation
  assign int_new = ({4'b0, int_digits} << 3) + ({4'b0, int_digits} << 1)
                   + (INT_W+4)'(dig);
  assign frac_new = ({4'b0, frac_digits} << 3) + ({4'b0, frac_digits} << 1)
                    + (FD_W+4)'(dig);

  // Fraction conversion: restoring long division by 10^count
  assign start_p = pow10(frac_count);
  assign r2 = {conv_r, 1'b0};
  assign r_ge = r2 >= {1'b0, conv_p};
  assign rnd = r_ge;
  assign f_round = {1'b0, conv_f} + (FRAC_BITS+1)'(rnd);
  assign conv_sat = nf_intsat || int_digits[INT_W-1];
  assign num_val = conv_sat ? VAL_MAX
                 : $signed({1'b0, int_digits[INT_W-2:0], {FRAC_BITS{1'b0}}}
                           + VAL_W'(f_round));

  // Term close: add or subtract the product term with saturation
  assign addend = sign ? VAL_W'(0) - product_term : product_term;
  assign sum_raw = running_sum + addend;
  assign add_ovf = (running_sum[VAL_W-1] == addend[VAL_W-1])
                   && (sum_raw[VAL_W-1] != running_sum[VAL_W-1]);
  assign sum_sat = add_ovf ? (running_sum[VAL_W-1] ? VAL_MIN : VAL_MAX) : sum_raw;

  iase_muldiv u_muldiv (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.md_start),
    .is_div_in (pending == PEND_DIV),
    .a         (product_term),
    .b         (num_val),
    .done      (md_done),
    .res       (md_res)
  );

  // Conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_busy <= 1'b0;
      conv_done <= 1'b0;
    end else begin
      conv_done <= 1'b0;
      if (cmd.conv_start) conv_busy <= 1'b1;
      else if (conv_busy && conv_cnt == CONV_CNT_W'(FRAC_BITS - 1)) begin
        conv_busy <= 1'b0;
        conv_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      conv_p <= start_p;
      conv_r <= (P_W'(frac_digits) >= start_p) ? '0 : P_W'(frac_digits);
      conv_f <= '0;
      conv_cnt <= '0;
    end else if (conv_busy) begin
      conv_r <= r_ge ? P_W'(r2 - {1'b0, conv_p}) : r2[P_W-1:0];
      conv_f <= {conv_f[FRAC_BITS-2:0], r_ge};
      conv_cnt <= conv_cnt + CONV_CNT_W'(1);
    end
  end

  // Captured character
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch <= char_item.character;
      last <= char_item.end_of_text;
    end
  end

  // Evaluation state
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      running_sum <= '0;
      product_term <= '0;
      int_digits <= '0;
      frac_digits <= '0;
      frac_count <= '0;
      nf_point <= 1'b0;
      nf_second <= 1'b0;
      nf_intsat <= 1'b0;
      err_div <= 1'b0;
      err_ovf <= 1'b0;
      sign <= 1'b0;
      pending <= PEND_NONE;
    end else begin
      if (cmd.number) begin
        if (ch == CH_POINT) begin
          if (nf_point) nf_second <= 1'b1;
          else nf_point <= 1'b1;
        end else if (nf_second) begin
          // digits after a second point are dropped
        end else if (nf_point) begin
          if (frac_count < FC_W'(MAX_FRAC_DIGITS)) begin
            frac_digits <= frac_new[FD_W-1:0];
            frac_count <= frac_count + FC_W'(1);
          end
        end else if (int_new[INT_W+3:INT_W] != '0) begin
          int_digits <= '1;
          nf_intsat <= 1'b1;
        end else begin
          int_digits <= int_new[INT_W-1:0];
        end
      end
      // Number consumed by a fold
      if (cmd.fold_set || cmd.md_start) begin
        int_digits <= '0;
        frac_digits <= '0;
        frac_count <= '0;
        nf_point <= 1'b0;
        nf_second <= 1'b0;
        nf_intsat <= 1'b0;
        if (conv_sat) err_ovf <= 1'b1;
      end
      if (cmd.fold_set) product_term <= num_val;
      if (cmd.md_commit) begin
        product_term <= md_res.value;
        if (md_res.ovf) err_ovf <= 1'b1;
        if (md_res.dz) err_div <= 1'b1;
      end
      if (cmd.set_pending) pending <= (ch == CH_STAR) ? PEND_MUL : PEND_DIV;
      if (cmd.close) begin
        running_sum <= sum_sat;
        product_term <= '0;
        pending <= PEND_NONE;
        if (add_ovf) err_ovf <= 1'b1;
      end
      if (cmd.set_sign) sign <= (ch == CH_MINUS);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (cmd.emit) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_item.result_value <= running_sum;
      result_item.divide_by_zero <= err_div;
      result_item.overflowed <= err_ovf;
    end
  end

endmodule
